[rtl/spq_pkg.sv]
package spq_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int VALUE_BITS_DEF    = 32;
	localparam int PRIORITY_BITS_DEF = 16;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_ADJUST = 3'd3,
		CMD_READ   = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2,
		STS_BAD   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} cell_op_t;

	typedef enum logic {
		ST_IDLE     = 1'b0,
		ST_REINSERT = 1'b1
	} state_t;

	typedef struct packed {
		cell_op_t op;
		logic     head_ins;
	} cell_ctrl_t;

endpackage

[rtl/spq_cmd_if.sv]
interface spq_cmd_if #(
	parameter int VB = 32,
	parameter int PB = 16,
	parameter int CW = 5
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           command;
	logic signed [VB-1:0] value;
	logic signed [PB-1:0] priority_req;
	logic [CW-1:0]        position;

	modport source (output valid, command, value, priority_req, position, input ready);
	modport sink (input valid, command, value, priority_req, position, output ready);
endinterface

[rtl/spq_rsp_if.sv]
interface spq_rsp_if #(
	parameter int VB = 32,
	parameter int PB = 16,
	parameter int CW = 5
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic signed [VB-1:0] out_value;
	logic signed [PB-1:0] out_priority;
	logic [CW-1:0]        entry_count;

	modport source (output valid, status, out_value, out_priority, entry_count, input ready);
	modport sink (input valid, status, out_value, out_priority, entry_count, output ready);
endinterface

[rtl/spq_cell.sv]
module spq_cell
	import spq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int VB  = 32,
	parameter int PB  = 16,
	parameter int CW  = 5,
	parameter int IW  = 4
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic [CW-1:0]        occ,
	input  logic [IW-1:0]        rm_idx,
	input  logic signed [VB-1:0] new_val,
	input  logic signed [PB-1:0] new_pri,
	input  logic                 left_after,
	input  logic signed [VB-1:0] left_val,
	input  logic signed [PB-1:0] left_pri,
	input  logic signed [VB-1:0] right_val,
	input  logic signed [PB-1:0] right_pri,
	output logic                 after,
	output logic signed [VB-1:0] val,
	output logic signed [PB-1:0] pri
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [IW-1:0] IDX_I = IW'(IDX);

	logic                 below;
	logic signed [VB-1:0] val_q;
	logic signed [PB-1:0] pri_q;

	// An empty cell, or one of lower priority, is where the new entry may land.
	always_comb begin
		below = (IDX_C >= occ) || (new_pri > pri_q);
		if (IDX == 0) begin
			after = ctrl.head_ins;
		end else begin
			after = ctrl.head_ins || below;
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (left_after) begin
					val_q <= left_val;
					pri_q <= left_pri;
				end else if (after) begin
					val_q <= new_val;
					pri_q <= new_pri;
				end
			end
			OP_REMOVE: begin
				if (IDX_I >= rm_idx) begin
					val_q <= right_val;
					pri_q <= right_pri;
				end
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign pri = pri_q;

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue of up to DEPTH entries (value, priority), held in
// descending order of priority in a row of cells, position one being the head.
// Commands arrive on the cmd channel and each gives exactly one response on
// the rsp channel, with a status, the head or read entry where relevant, and
// the number of entries held afterwards.
// Insert, pop, peek, read and clear complete in one step: the response is
// registered and valid in the cycle after the transfer, and a new command is
// taken in every cycle unless the response stalls. Adjust removes and then
// reinserts through the same row of cells, so cmd.ready is low for one cycle
// after an adjust transfer; its response is registered as the reinsert is done.
// Reset empties the queue at once; the entry storage itself is not cleared.
// When the receiver stalls, the response is held and cmd.ready falls until
// the response transfer takes place.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int VALUE_BITS    = VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	spq_cmd_if.sink  cmd,
	spq_rsp_if.source rsp
);

	localparam int VB = VALUE_BITS;
	localparam int PB = PRIORITY_BITS;
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	state_t               state_q, state_d;
	logic [CW-1:0]        occ_q, occ_d;
	logic                 rsp_valid_q, rsp_valid_d;
	status_t              rsp_status_q, rsp_status_d;
	logic signed [VB-1:0] rsp_val_q, rsp_val_d;
	logic signed [PB-1:0] rsp_pri_q, rsp_pri_d;
	logic [CW-1:0]        rsp_cnt_q;
	logic                 rsp_load;
	logic signed [VB-1:0] adj_val_q, adj_val_d;
	logic signed [PB-1:0] adj_pri_q, adj_pri_d;

	cell_ctrl_t           ctrl;
	logic [IW-1:0]        rm_idx;
	logic [IW-1:0]        idx;
	logic signed [VB-1:0] new_val;
	logic signed [PB-1:0] new_pri;
	logic                 accept;
	logic                 pos_bad;

	logic                 cell_after [DEPTH];
	logic signed [VB-1:0] cell_val   [DEPTH];
	logic signed [PB-1:0] cell_pri   [DEPTH];

	assign cmd.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign pos_bad   = (cmd.position == '0) || (cmd.position > occ_q);
	assign idx       = IW'(cmd.position - ONE_C);

	always_comb begin
		state_d      = state_q;
		occ_d        = occ_q;
		ctrl.op      = OP_HOLD;
		rm_idx       = '0;
		new_val      = cmd.value;
		new_pri      = cmd.priority_req;
		adj_val_d    = adj_val_q;
		adj_pri_d    = adj_pri_q;
		rsp_load     = 1'b0;
		rsp_status_d = STS_OK;
		rsp_val_d    = '0;
		rsp_pri_d    = '0;
		if (state_q == ST_REINSERT) begin
			new_val  = adj_val_q;
			new_pri  = adj_pri_q;
			ctrl.op  = OP_INSERT;
			occ_d    = occ_q + ONE_C;
			rsp_load = 1'b1;
			state_d  = ST_IDLE;
		end else if (accept) begin
			rsp_load = 1'b1;
			case (cmd_t'(cmd.command))
				CMD_INSERT: begin
					if (occ_q == FULL_C) begin
						rsp_status_d = STS_FULL;
					end else begin
						ctrl.op = OP_INSERT;
						occ_d   = occ_q + ONE_C;
					end
				end
				CMD_POP, CMD_PEEK: begin
					if (occ_q == '0) begin
						rsp_status_d = STS_EMPTY;
					end else begin
						rsp_val_d = cell_val[0];
						rsp_pri_d = cell_pri[0];
						if (cmd_t'(cmd.command) == CMD_POP) begin
							ctrl.op = OP_REMOVE;
							occ_d   = occ_q - ONE_C;
						end
					end
				end
				CMD_ADJUST, CMD_READ: begin
					if (occ_q == '0) begin
						rsp_status_d = STS_EMPTY;
					end else if (pos_bad) begin
						rsp_status_d = STS_BAD;
					end else if (cmd_t'(cmd.command) == CMD_READ) begin
						rsp_val_d = cell_val[idx];
						rsp_pri_d = cell_pri[idx];
					end else begin
						ctrl.op   = OP_REMOVE;
						rm_idx    = idx;
						occ_d     = occ_q - ONE_C;
						adj_val_d = cell_val[idx];
						adj_pri_d = cmd.priority_req;
						rsp_load  = 1'b0;
						state_d   = ST_REINSERT;
					end
				end
				CMD_CLEAR: begin
					occ_d = '0;
				end
				default: begin
				end
			endcase
		end
		ctrl.head_ins = (occ_q == '0) || (new_pri >= cell_pri[0]);
		if (rsp_load) begin
			rsp_valid_d = 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		adj_val_q <= adj_val_d;
		adj_pri_q <= adj_pri_d;
		if (rsp_load) begin
			rsp_status_q <= rsp_status_d;
			rsp_val_q    <= rsp_val_d;
			rsp_pri_q    <= rsp_pri_d;
			rsp_cnt_q    <= occ_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 l_after;
		logic signed [VB-1:0] l_val, r_val;
		logic signed [PB-1:0] l_pri, r_pri;

		if (i == 0) begin : g_first
			assign l_after = 1'b0;
			assign l_val   = cell_val[0];
			assign l_pri   = cell_pri[0];
		end else begin : g_mid
			assign l_after = cell_after[i-1];
			assign l_val   = cell_val[i-1];
			assign l_pri   = cell_pri[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign r_val = cell_val[i];
			assign r_pri = cell_pri[i];
		end else begin : g_inner
			assign r_val = cell_val[i+1];
			assign r_pri = cell_pri[i+1];
		end

		spq_cell #(
			.IDX (i),
			.VB  (VB),
			.PB  (PB),
			.CW  (CW),
			.IW  (IW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occ        (occ_q),
			.rm_idx     (rm_idx),
			.new_val    (new_val),
			.new_pri    (new_pri),
			.left_after (l_after),
			.left_val   (l_val),
			.left_pri   (l_pri),
			.right_val  (r_val),
			.right_pri  (r_pri),
			.after      (cell_after[i]),
			.val        (cell_val[i]),
			.pri        (cell_pri[i])
		);
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.out_value    = rsp_val_q;
	assign rsp.out_priority = rsp_pri_q;
	assign rsp.entry_count  = rsp_cnt_q;

endmodule

[rtl/spq_checker.sv]
module spq_checker
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int VB    = VALUE_BITS_DEF,
	parameter int PB    = PRIORITY_BITS_DEF,
	parameter int CW    = $clog2(DEPTH_DEF + 1)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input logic [1:0]    status,
	input logic [VB-1:0] out_value,
	input logic [PB-1:0] out_priority,
	input logic [CW-1:0] entry_count
);

	// A stalled response holds still until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_value)
			&& $stable(out_priority) && $stable(entry_count))
		else $error("response changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STS_EMPTY |-> entry_count == '0)
		else $error("empty status with entries held");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STS_FULL |-> entry_count == CW'(DEPTH))
		else $error("full status without a full queue");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STS_OK |-> out_value == '0 && out_priority == '0)
		else $error("error response carries an entry");

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH (DEPTH),
	.VB    (VALUE_BITS),
	.PB    (PRIORITY_BITS),
	.CW    ($clog2(DEPTH + 1))
) u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.out_value    (rsp.out_value),
	.out_priority (rsp.out_priority),
	.entry_count  (rsp.entry_count)
);
